[hw/rtl/iaid_pkg.sv]
// Shared constants, codes and structs for the indexed array insert/delete unit
`timescale 1ns / 1ps
`default_nettype none
package iaid_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = CNT_W + 1;
    localparam int OP_W     = 3;
    localparam int ST_W     = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT     = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE     = 3'd1;
    localparam logic [OP_W-1:0] OP_DROP_EVEN  = 3'd2;
    localparam logic [OP_W-1:0] OP_EXPAND_ODD = 3'd3;
    localparam logic [OP_W-1:0] OP_READ       = 3'd4;

    // status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    // memory port request from the sequencer
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    // finished transaction handed to the output register
    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]         list_length;
        logic [ST_W-1:0]          status;
    } result_t;

endpackage
`default_nettype wire

[hw/rtl/iaid_chan_if.sv]
// Valid/ready channel interfaces for requests and responses
`timescale 1ns / 1ps
`default_nettype none
interface iaid_req_if
    import iaid_pkg::*;
    ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic [CNT_W-1:0]         position;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output op, output position, output value, input ready);
    modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface iaid_rsp_if
    import iaid_pkg::*;
    ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]         list_length;
    logic [ST_W-1:0]          status;

    modport source (output valid, output read_value, output list_length, output status,
                    input ready);
    modport sink   (input valid, input read_value, input list_length, input status,
                    output ready);
endinterface
`default_nettype wire

[hw/rtl/iaid_seq.sv]
// Sequencer: walks the list one entry at a time through the shared memory port
`timescale 1ns / 1ps
`default_nettype none
module iaid_seq
    import iaid_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     req_valid,
    output logic                          req_ready,
    input  wire logic [OP_W-1:0]          req_op,
    input  wire logic [CNT_W-1:0]         req_position,
    input  wire logic signed [DATA_W-1:0] req_value,
    input  wire logic                     out_free,
    input  wire logic [DATA_W-1:0]        mem_rdata,
    output mem_req_t                      mem_req,
    output result_t                       result
);

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [SUM_W-1:0] CAP_SUM = SUM_W'(CAPACITY);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_START = 8'b0000_0010,
        S_RD    = 8'b0000_0100,
        S_WR    = 8'b0000_1000,
        S_ZERO  = 8'b0001_0000,
        S_CHK   = 8'b0010_0000,
        S_PUT   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [SUM_W-1:0]  w_reg, w_next;
    logic              phase_reg, phase_next;
    logic [ST_W-1:0]   status_reg, status_next;
    logic [DATA_W-1:0] rdval_reg, rdval_next;
    logic [DATA_W-1:0] hold_reg, hold_next;

    logic [SUM_W-1:0]  idx_inc;
    logic [SUM_W-1:0]  w_dec;
    logic [SUM_W-1:0]  sum;

    // shared index arithmetic
    assign idx_inc = {1'b0, idx_reg} + SUM_W'(1);
    assign w_dec   = w_reg - SUM_W'(1);
    assign sum     = {1'b0, count_reg} + w_reg;

    assign req_ready = (state_reg == S_IDLE);

    // next-state and datapath control
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        w_next      = w_reg;
        phase_next  = phase_reg;
        status_next = status_reg;
        rdval_next  = rdval_reg;
        hold_next   = hold_reg;

        mem_req.we    = 1'b0;
        mem_req.waddr = idx_reg[ADDR_W-1:0];
        mem_req.wdata = mem_rdata;
        mem_req.raddr = idx_reg[ADDR_W-1:0];

        result.done        = 1'b0;
        result.read_value  = rdval_reg;
        result.list_length = count_reg;
        result.status      = status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next     = req_op;
                    pos_next    = req_position;
                    val_next    = req_value;
                    status_next = ST_OK;
                    rdval_next  = '0;
                    state_next  = S_START;
                end
            end

            S_START:
            begin
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (pos_reg > count_reg)
                        begin
                            status_next = ST_RANGE;
                            state_next  = S_DONE;
                        end
                        else if (count_reg >= CAP_CNT)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else if (pos_reg == count_reg)
                        begin
                            state_next = S_PUT;
                        end
                        else
                        begin
                            idx_next   = count_reg - CNT_W'(1);
                            state_next = S_RD;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (pos_reg >= count_reg)
                        begin
                            status_next = ST_RANGE;
                            state_next  = S_DONE;
                        end
                        else if ({1'b0, pos_reg} + SUM_W'(1) >= {1'b0, count_reg})
                        begin
                            state_next = S_PUT;
                        end
                        else
                        begin
                            idx_next   = pos_reg + CNT_W'(1);
                            state_next = S_RD;
                        end
                    end
                    OP_DROP_EVEN:
                    begin
                        idx_next   = '0;
                        w_next     = '0;
                        state_next = (count_reg == '0) ? S_PUT : S_RD;
                    end
                    OP_EXPAND_ODD:
                    begin
                        idx_next   = '0;
                        w_next     = '0;
                        phase_next = 1'b0;
                        state_next = (count_reg == '0) ? S_DONE : S_RD;
                    end
                    OP_READ:
                    begin
                        if (pos_reg >= count_reg)
                        begin
                            status_next = ST_RANGE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            idx_next   = pos_reg;
                            state_next = S_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // read data shows up in the following cycle
            S_RD:
            begin
                state_next = S_WR;
            end

            S_WR:
            begin
                case (op_reg)
                    OP_INSERT:
                    begin
                        // move entry up by one
                        mem_req.we    = 1'b1;
                        mem_req.waddr = idx_inc[ADDR_W-1:0];
                        if (idx_reg == pos_reg)
                        begin
                            state_next = S_PUT;
                        end
                        else
                        begin
                            idx_next   = idx_reg - CNT_W'(1);
                            state_next = S_RD;
                        end
                    end
                    OP_DELETE:
                    begin
                        // move entry down by one
                        mem_req.we    = 1'b1;
                        mem_req.waddr = idx_reg[ADDR_W-1:0] - ADDR_W'(1);
                        if (idx_inc >= {1'b0, count_reg})
                        begin
                            state_next = S_PUT;
                        end
                        else
                        begin
                            idx_next   = idx_inc[CNT_W-1:0];
                            state_next = S_RD;
                        end
                    end
                    OP_DROP_EVEN:
                    begin
                        // keep odd entries packed at the write pointer
                        if (mem_rdata[0])
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = w_reg[ADDR_W-1:0];
                            w_next        = w_reg + SUM_W'(1);
                        end
                        if (idx_inc == {1'b0, count_reg})
                        begin
                            state_next = S_PUT;
                        end
                        else
                        begin
                            idx_next   = idx_inc[CNT_W-1:0];
                            state_next = S_RD;
                        end
                    end
                    OP_EXPAND_ODD:
                    begin
                        if (!phase_reg)
                        begin
                            // counting pass
                            if (mem_rdata[0])
                            begin
                                w_next = w_reg + SUM_W'(1);
                            end
                            if (idx_inc == {1'b0, count_reg})
                            begin
                                state_next = S_CHK;
                            end
                            else
                            begin
                                idx_next   = idx_inc[CNT_W-1:0];
                                state_next = S_RD;
                            end
                        end
                        else
                        begin
                            // spreading pass, top down
                            hold_next     = mem_rdata;
                            mem_req.we    = 1'b1;
                            mem_req.waddr = w_dec[ADDR_W-1:0];
                            w_next        = w_dec;
                            if (mem_rdata[0])
                            begin
                                mem_req.wdata = '0;
                                state_next    = S_ZERO;
                            end
                            else if (idx_reg == '0)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                idx_next   = idx_reg - CNT_W'(1);
                                state_next = S_RD;
                            end
                        end
                    end
                    OP_READ:
                    begin
                        rdval_next = mem_rdata;
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // odd entry lands below its inserted zero
            S_ZERO:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = w_dec[ADDR_W-1:0];
                mem_req.wdata = hold_reg;
                w_next        = w_dec;
                if (idx_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg - CNT_W'(1);
                    state_next = S_RD;
                end
            end

            // capacity check before the spreading pass
            S_CHK:
            begin
                if (sum > CAP_SUM)
                begin
                    status_next = ST_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    w_next     = sum;
                    count_next = sum[CNT_W-1:0];
                    idx_next   = count_reg - CNT_W'(1);
                    phase_next = 1'b1;
                    state_next = S_RD;
                end
            end

            // final length update, plus the write of an inserted value
            S_PUT:
            begin
                case (op_reg)
                    OP_INSERT:
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = pos_reg[ADDR_W-1:0];
                        mem_req.wdata = val_reg;
                        count_next    = count_reg + CNT_W'(1);
                    end
                    OP_DELETE:
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    OP_DROP_EVEN:
                    begin
                        count_next = w_reg[CNT_W-1:0];
                    end
                    default:
                    begin
                        count_next = count_reg;
                    end
                endcase
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    result.done = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        idx_reg    <= idx_next;
        w_reg      <= w_next;
        phase_reg  <= phase_next;
        status_reg <= status_next;
        rdval_reg  <= rdval_next;
        hold_reg   <= hold_next;
    end

    // length never passes capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("list length above capacity");

    // length moves only on the final update or the expansion check
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_PUT && state_reg != S_CHK) |=> $stable(count_reg))
        else $error("list length changed outside its update states");

    // spreading writes never go below the entry being read
    a_spread_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR && op_reg == OP_EXPAND_ODD && phase_reg)
            |-> (w_reg > {1'b0, idx_reg}))
        else $error("expansion write would clobber unread entry");

    // a result leaves only when the output register can take it
    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        result.done |-> (out_free && state_reg == S_DONE))
        else $error("result issued without room");

endmodule
`default_nettype wire

[hw/rtl/indexed_array_insert_delete_unit.sv]
// Top level: element memory, sequencer and response register
//
//  channel | modport     | payload                              | accepted when
//  req     | iaid sink   | op, position, value                  | req.valid && req.ready
//  rsp     | iaid source | read_value, list_length, status      | rsp.valid && rsp.ready
//
// A transaction holds the unit while it moves or scans entries one at a time
// (one memory read per entry, then up to two writes), with setup and wrap-up states around
// that; expand-odd makes a counting pass, then a spreading pass top down.
// The element memory has one write port and one registered read port.
// Reset clears the length and the control state; the memory is not cleared.
// req.ready is high only while the sequencer is idle; a response waiting on a
// stalled rsp channel does not block the next request from being taken.
`timescale 1ns / 1ps
`default_nettype none
module indexed_array_insert_delete_unit
    import iaid_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    iaid_req_if.sink  req,
    iaid_rsp_if.source rsp
);

    mem_req_t          mem_req;
    result_t           result;
    logic              out_free;
    logic [DATA_W-1:0] mem_array [CAPACITY];
    logic [DATA_W-1:0] mem_rdata_reg;

    logic                     rsp_valid_reg;
    logic signed [DATA_W-1:0] rsp_value_reg;
    logic [CNT_W-1:0]         rsp_length_reg;
    logic [ST_W-1:0]          rsp_status_reg;

    assign out_free = !rsp_valid_reg || rsp.ready;

    iaid_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req.valid),
        .req_ready    (req.ready),
        .req_op       (req.op),
        .req_position (req.position),
        .req_value    (req.value),
        .out_free     (out_free),
        .mem_rdata    (mem_rdata_reg),
        .mem_req      (mem_req),
        .result       (result)
    );

    // element memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem_array[mem_req.waddr] <= mem_req.wdata;
        end
        mem_rdata_reg <= mem_array[mem_req.raddr];
    end

    // response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (result.done)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (result.done)
        begin
            rsp_value_reg  <= result.read_value;
            rsp_length_reg <= result.list_length;
            rsp_status_reg <= result.status;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.read_value  = rsp_value_reg;
    assign rsp.list_length = rsp_length_reg;
    assign rsp.status      = rsp_status_reg;

endmodule
`default_nettype wire

[tb/list_checker.sv]
// Transaction monitor and scoreboard for the indexed array insert/delete unit
`timescale 1ns / 1ps
module list_checker
    import iaid_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    iaid_req_if               req,
    iaid_rsp_if               rsp,
    output int                fail_count,
    output int                pending,
    output logic [CNT_W-1:0]  model_length
);

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]         list_length;
        logic [ST_W-1:0]          status;
    } list_reply_t;

    // shadow copy of the list
    logic signed [DATA_W-1:0] shadow_list [CAPACITY];
    logic [CNT_W-1:0]         shadow_len = '0;

    list_reply_t      reply_q [$];
    int               mismatches = 0;
    int               responses = 0;
    int               backlog = 0;
    logic [CNT_W-1:0] len_seen = '0;

    assign fail_count   = mismatches;
    assign pending      = backlog;
    assign model_length = len_seen;

    // apply one operation to the shadow list and return the reply it should give
    function automatic list_reply_t apply_list_op(input logic [OP_W-1:0] op,
                                                  input logic [CNT_W-1:0] pos,
                                                  input logic signed [DATA_W-1:0] val);
        list_reply_t              r;
        int                       n;
        int                       i;
        int                       w;
        int                       odds;
        logic signed [DATA_W-1:0] spread [CAPACITY];
        r = '0;
        r.status = ST_OK;
        n = int'(shadow_len);
        case (op)
            OP_INSERT: begin
                if (int'(pos) > n) begin
                    r.status = ST_RANGE;
                end else if (n >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = n; i > int'(pos); i--) begin
                        shadow_list[i] = shadow_list[i-1];
                    end
                    shadow_list[pos] = val;
                    n++;
                end
            end
            OP_DELETE: begin
                if (int'(pos) >= n) begin
                    r.status = ST_RANGE;
                end else begin
                    for (i = int'(pos) + 1; i < n; i++) begin
                        shadow_list[i-1] = shadow_list[i];
                    end
                    n--;
                end
            end
            OP_DROP_EVEN: begin
                // keep odd entries in order; parity is the low bit, sign ignored
                w = 0;
                for (i = 0; i < n; i++) begin
                    if (shadow_list[i][0]) begin
                        shadow_list[w] = shadow_list[i];
                        w++;
                    end
                end
                n = w;
            end
            OP_EXPAND_ODD: begin
                odds = 0;
                for (i = 0; i < n; i++) begin
                    if (shadow_list[i][0]) begin
                        odds++;
                    end
                end
                if (n + odds > CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    w = 0;
                    for (i = 0; i < n; i++) begin
                        spread[w] = shadow_list[i];
                        w++;
                        if (shadow_list[i][0]) begin
                            spread[w] = '0;
                            w++;
                        end
                    end
                    for (i = 0; i < w; i++) begin
                        shadow_list[i] = spread[i];
                    end
                    n = w;
                end
            end
            OP_READ: begin
                if (int'(pos) >= n) begin
                    r.status = ST_RANGE;
                end else begin
                    r.read_value = shadow_list[pos];
                end
            end
            default: begin
                // spare op codes: no change, status ok
            end
        endcase
        shadow_len = CNT_W'(n);
        r.list_length = shadow_len;
        return r;
    endfunction

    // count a failure; only the first few get printed
    function automatic bit log_mismatch();
        mismatches++;
        return (mismatches <= 10);
    endfunction

    // predict on request, compare on response
    always @(posedge clk or negedge rst_n) begin
        list_reply_t want;
        if (!rst_n) begin
            shadow_len = '0;
            reply_q.delete();
        end else begin
            if (req.valid && req.ready) begin
                reply_q.push_back(apply_list_op(req.op, req.position, req.value));
            end
            if (rsp.valid && rsp.ready) begin
                responses++;
                if (reply_q.size() == 0) begin
                    if (log_mismatch()) begin
                        $display("response %0d unexpected: read_value=%0d length=%0d status=%0d",
                                 responses, rsp.read_value, rsp.list_length, rsp.status);
                    end
                end else begin
                    want = reply_q.pop_front();
                    if (rsp.read_value !== want.read_value ||
                        rsp.list_length !== want.list_length ||
                        rsp.status !== want.status) begin
                        if (log_mismatch()) begin
                            $display("response %0d: read_value exp %0d got %0d",
                                     responses, want.read_value, rsp.read_value);
                            $display("    length exp %0d got %0d, status exp %0d got %0d",
                                     want.list_length, rsp.list_length,
                                     want.status, rsp.status);
                        end
                    end
                end
            end
        end
        backlog  <= reply_q.size();
        len_seen <= shadow_len;
    end

endmodule

[tb/testbench.sv]
// Top-level testbench: clock, reset, request/response traffic and verdict
`timescale 1ns / 1ps
module testbench;
    import iaid_pkg::*;

    // spare op codes the unit must ignore
    localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

    localparam int RANDOM_ITEMS = 850;
    localparam int DRAIN_CYCLES = 400;

    typedef enum {PM_GIVEN, PM_VALID, PM_EDGE, PM_BEYOND, PM_ANY} pos_pick_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    bit               steady = 1'b0;
    int               sent = 0;
    int               fail_count;
    int               pending;
    logic [CNT_W-1:0] model_length;

    iaid_req_if req_ch ();
    iaid_rsp_if rsp_ch ();

    indexed_array_insert_delete_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    list_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .fail_count   (fail_count),
        .pending      (pending),
        .model_length (model_length)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // safety net
    initial
    begin
        #15_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // response side: random back-pressure
    initial
    begin
        int stall;
        forever begin
            stall = steady ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
        end
    end

    function automatic logic signed [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] rand_op();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)      return OP_INSERT;
        else if (roll < 55) return OP_DELETE;
        else if (roll < 80) return OP_READ;
        else if (roll < 87) return OP_DROP_EVEN;
        else if (roll < 97) return OP_EXPAND_ODD;
        else                return OP_SPARE_LO + OP_W'($urandom_range(0, 2));
    endfunction

    function automatic pos_pick_t rand_pick();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)      return PM_VALID;
        else if (roll < 82) return PM_EDGE;
        else if (roll < 92) return PM_BEYOND;
        else                return PM_ANY;
    endfunction

    // one request transaction; position is picked after the idle gap
    task automatic issue(input logic [OP_W-1:0] op, input pos_pick_t pick,
                         input logic [CNT_W-1:0] fixed_pos,
                         input logic signed [DATA_W-1:0] val);
        int               gap;
        int               hi_ok;
        logic [CNT_W-1:0] pos;
        gap = steady ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        // highest in-range position for this op
        hi_ok = (op == OP_INSERT) ? int'(model_length) : int'(model_length) - 1;
        case (pick)
            PM_GIVEN:  pos = fixed_pos;
            PM_VALID:  pos = (hi_ok < 0) ? '0 : CNT_W'($urandom_range(0, hi_ok));
            PM_EDGE:   pos = (hi_ok < 0) ? '0 : CNT_W'(hi_ok + $urandom_range(0, 1));
            PM_BEYOND: pos = CNT_W'($urandom_range(hi_ok + 1, 127));
            default:   pos = CNT_W'($urandom_range(0, 127));
        endcase
        req_ch.valid    <= 1'b1;
        req_ch.op       <= op;
        req_ch.position <= pos;
        req_ch.value    <= val;
        do @(posedge clk); while (!req_ch.ready);
        if (op <= OP_READ) begin
            sent++;
        end
    endtask

    // stimulus and verdict
    initial
    begin
        req_ch.valid    <= 1'b0;
        req_ch.op       <= OP_INSERT;
        req_ch.position <= '0;
        req_ch.value    <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list, signed extremes, parity of negatives, bad positions
        issue(OP_READ,       PM_GIVEN, 7'd0,   32'sd5);
        issue(OP_DELETE,     PM_GIVEN, 7'd0,   32'sd5);
        issue(OP_DROP_EVEN,  PM_GIVEN, 7'd0,   '0);
        issue(OP_EXPAND_ODD, PM_GIVEN, 7'd0,   '0);
        issue(OP_INSERT,     PM_GIVEN, 7'd1,   32'sd9);
        issue(OP_INSERT,     PM_GIVEN, 7'd0,   32'sh7FFF_FFFF);
        issue(OP_INSERT,     PM_GIVEN, 7'd1,   32'sh8000_0000);
        issue(OP_INSERT,     PM_GIVEN, 7'd0,   -32'sd1);
        issue(OP_INSERT,     PM_GIVEN, 7'd3,   -32'sd2);
        issue(OP_INSERT,     PM_GIVEN, 7'd127, 32'sd3);
        issue(OP_READ,       PM_GIVEN, 7'd0,   '0);
        issue(OP_READ,       PM_GIVEN, 7'd3,   '0);
        issue(OP_READ,       PM_GIVEN, 7'd4,   '0);
        issue(OP_READ,       PM_GIVEN, 7'd127, '0);
        issue(OP_EXPAND_ODD, PM_GIVEN, 7'd0,   '0);
        issue(OP_READ,       PM_GIVEN, 7'd1,   '0);
        issue(OP_DROP_EVEN,  PM_GIVEN, 7'd0,   '0);
        issue(OP_DELETE,     PM_GIVEN, 7'd2,   '0);
        issue(OP_DELETE,     PM_GIVEN, 7'd127, '0);
        issue(OP_DELETE,     PM_GIVEN, 7'd0,   '0);
        issue(OP_SPARE_LO,   PM_GIVEN, 7'd0,   -32'sd1);
        issue(OP_SPARE_MID,  PM_GIVEN, 7'd85,  32'sh5555_5555);
        issue(OP_SPARE_HI,   PM_GIVEN, 7'd42,  32'shAAAA_AAAA);
        issue(OP_DELETE,     PM_GIVEN, 7'd0,   '0);
        issue(OP_INSERT,     PM_GIVEN, 7'd0,   '0);

        // random phases: fill to capacity, drain to empty, or mixed traffic
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 5))
                0, 1: begin
                    while (int'(model_length) < CAPACITY) begin
                        issue(OP_INSERT, PM_VALID, '0, rand_value());
                    end
                    // full list: refused insert, expansions, edge read, drop even
                    issue(OP_INSERT,     PM_VALID, '0, rand_value());
                    issue(OP_EXPAND_ODD, PM_GIVEN, '0, '0);
                    issue(OP_READ,       PM_EDGE,  '0, '0);
                    issue(OP_DROP_EVEN,  PM_GIVEN, '0, '0);
                    issue(OP_EXPAND_ODD, PM_GIVEN, '0, '0);
                    issue(OP_READ,       PM_VALID, '0, '0);
                end
                2: begin
                    while (model_length != '0) begin
                        issue(OP_DELETE, PM_VALID, '0, rand_value());
                    end
                    issue(OP_DELETE, PM_ANY, '0, rand_value());
                    issue(OP_READ,   PM_ANY, '0, rand_value());
                end
                default: begin
                    repeat (30) issue(rand_op(), rand_pick(), '0, rand_value());
                end
            endcase
        end
        req_ch.valid <= 1'b0;
        steady = 1'b0;

        // wait out outstanding responses, then a quiet tail
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/iaid_pkg.sv
hw/rtl/iaid_chan_if.sv
hw/rtl/iaid_seq.sv
hw/rtl/indexed_array_insert_delete_unit.sv
tb/list_checker.sv
tb/testbench.sv
